// File: sv/rpp_pkg.sv
// Shared types, widths and constants of the point projection pipeline.
package rpp_pkg;

    localparam int COORD_WIDTH    = 24;
    localparam int TRIG_FRAC_BITS = 14;
    localparam int TRIG_W         = 16;
    localparam int DIST_W         = 24;
    localparam int GAIN_W         = 24;
    localparam int SCR_W          = 14;
    localparam int OUT_W          = 28;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 24;
    localparam int LANES          = 2;
    localparam int LANE_X         = 0;
    localparam int LANE_Y         = 1;

    localparam int TRIG_MASK   = (1 << TRIG_FRAC_BITS) - 1;
    localparam int DEPTH_FRAC  = 8;
    localparam int ONE_Q8      = 1 << DEPTH_FRAC;
    localparam int SUB_SHIFT   = 4;
    localparam int CENTRE_SHIFT = 3;

    // rotation stage widths
    localparam int P1_W = COORD_WIDTH + TRIG_W;
    localparam int S1_W = P1_W + 1;
    localparam int R1_W = S1_W - TRIG_FRAC_BITS;
    localparam int P2_W = R1_W + TRIG_W;
    localparam int S2_W = P2_W + 1;
    localparam int R2_W = S2_W - TRIG_FRAC_BITS;

    // projection and divider widths
    localparam int DEPTH_W    = R2_W + DEPTH_FRAC + 1;
    localparam int DEN_W      = DEPTH_W - 1;
    localparam int MX_W       = R1_W + GAIN_W + 1;
    localparam int MY_W       = R2_W + GAIN_W + 1;
    localparam int NUM_W      = MY_W + SUB_SHIFT - 1;
    localparam int QB         = OUT_W;
    localparam int REM_W      = DEN_W + 1;
    localparam int DIV_STAGES = QB + 1;
    localparam int SUM_W      = OUT_W + 2;

    localparam int OUT_MAX = (1 << (OUT_W - 1)) - 1;
    localparam int OUT_MIN = -(1 << (OUT_W - 1));

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COS_YAW         = 3'd0,
        REG_SIN_YAW         = 3'd1,
        REG_COS_PITCH       = 3'd2,
        REG_SIN_PITCH       = 3'd3,
        REG_CAMERA_DISTANCE = 3'd4,
        REG_PROJ_GAIN       = 3'd5,
        REG_SCREEN_WIDTH    = 3'd6,
        REG_SCREEN_HEIGHT   = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic signed [TRIG_W-1:0] cos_yaw;
        logic signed [TRIG_W-1:0] sin_yaw;
        logic signed [TRIG_W-1:0] cos_pitch;
        logic signed [TRIG_W-1:0] sin_pitch;
        logic [DIST_W-1:0]        camera_distance;
        logic [GAIN_W-1:0]        proj_gain;
        logic [SCR_W-1:0]         screen_width;
        logic [SCR_W-1:0]         screen_height;
    } t_cfg;

endpackage

// File: sv/rpp_cfg.sv
// Configuration register file of the point projection pipeline.
module rpp_cfg import rpp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cos_yaw         <= TRIG_W'(16384);
            r_cfg.sin_yaw         <= '0;
            r_cfg.cos_pitch       <= TRIG_W'(16384);
            r_cfg.sin_pitch       <= '0;
            r_cfg.camera_distance <= DIST_W'(128000);
            r_cfg.proj_gain       <= GAIN_W'(256);
            r_cfg.screen_width    <= SCR_W'(800);
            r_cfg.screen_height   <= SCR_W'(600);
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_COS_YAW:         r_cfg.cos_yaw <= i_cfg_data[TRIG_W-1:0];
                REG_SIN_YAW:         r_cfg.sin_yaw <= i_cfg_data[TRIG_W-1:0];
                REG_COS_PITCH:       r_cfg.cos_pitch <= i_cfg_data[TRIG_W-1:0];
                REG_SIN_PITCH:       r_cfg.sin_pitch <= i_cfg_data[TRIG_W-1:0];
                REG_CAMERA_DISTANCE: r_cfg.camera_distance <= i_cfg_data[DIST_W-1:0];
                REG_PROJ_GAIN:       r_cfg.proj_gain <= i_cfg_data[GAIN_W-1:0];
                REG_SCREEN_WIDTH:    r_cfg.screen_width <= i_cfg_data[SCR_W-1:0];
                REG_SCREEN_HEIGHT:   r_cfg.screen_height <= i_cfg_data[SCR_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: sv/rpp_rotate.sv
// Four-stage yaw then pitch rotation of one point per cycle while i_en is high.
module rpp_rotate import rpp_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  t_cfg                          i_cfg,
    input  logic                          i_valid,
    input  logic signed [COORD_WIDTH-1:0] i_pos_x,
    input  logic signed [COORD_WIDTH-1:0] i_pos_y,
    input  logic signed [COORD_WIDTH-1:0] i_pos_z,
    output logic                          o_valid,
    output logic signed [R1_W-1:0]        o_x1,
    output logic signed [R2_W-1:0]        o_y2,
    output logic signed [R2_W-1:0]        o_z2
);

    // divide by 2^frac, rounding toward zero
    function automatic logic signed [R1_W-1:0] trunc1(input logic signed [S1_W-1:0] s);
        logic signed [S1_W-1:0] b;
        b = s[S1_W-1] ? S1_W'(TRIG_MASK) : '0;
        return R1_W'((s + b) >>> TRIG_FRAC_BITS);
    endfunction

    function automatic logic signed [R2_W-1:0] trunc2(input logic signed [S2_W-1:0] s);
        logic signed [S2_W-1:0] b;
        b = s[S2_W-1] ? S2_W'(TRIG_MASK) : '0;
        return R2_W'((s + b) >>> TRIG_FRAC_BITS);
    endfunction

    logic [3:0] r_v;
    logic signed [P1_W-1:0]        r_pxc, r_pzs, r_pzc, r_pxs;
    logic signed [COORD_WIDTH-1:0] r_y1, r_yd;
    logic signed [R1_W-1:0]        r_x1, r_z1, r_x1d, r_x1o;
    logic signed [P2_W-1:0]        r_pyc, r_pz1s, r_pys, r_pz1c;
    logic signed [R2_W-1:0]        r_y2, r_z2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // yaw products
            r_pxc <= $signed(i_cfg.cos_yaw) * i_pos_x;
            r_pzs <= $signed(i_cfg.sin_yaw) * i_pos_z;
            r_pzc <= $signed(i_cfg.cos_yaw) * i_pos_z;
            r_pxs <= $signed(i_cfg.sin_yaw) * i_pos_x;
            r_y1  <= i_pos_y;
            // yaw sums
            r_x1  <= trunc1(S1_W'(r_pxc) + S1_W'(r_pzs));
            r_z1  <= trunc1(S1_W'(r_pzc) - S1_W'(r_pxs));
            r_yd  <= r_y1;
            // pitch products
            r_pyc  <= $signed(i_cfg.cos_pitch) * r_yd;
            r_pz1s <= $signed(i_cfg.sin_pitch) * r_z1;
            r_pys  <= $signed(i_cfg.sin_pitch) * r_yd;
            r_pz1c <= $signed(i_cfg.cos_pitch) * r_z1;
            r_x1d  <= r_x1;
            // pitch sums
            r_y2  <= trunc2(S2_W'(r_pyc) - S2_W'(r_pz1s));
            r_z2  <= trunc2(S2_W'(r_pys) + S2_W'(r_pz1c));
            r_x1o <= r_x1d;
        end
    end

    assign o_valid = r_v[3];
    assign o_x1    = r_x1o;
    assign o_y2    = r_y2;
    assign o_z2    = r_z2;

endmodule

// File: sv/rpp_project.sv
// Depth clamp, gain multiply and numerator magnitudes, two stages.
module rpp_project import rpp_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  t_cfg                          i_cfg,
    input  logic                          i_valid,
    input  logic signed [R1_W-1:0]        i_x1,
    input  logic signed [R2_W-1:0]        i_y2,
    input  logic signed [R2_W-1:0]        i_z2,
    output logic                          o_valid,
    output logic                          o_clamp,
    output logic [DEN_W-1:0]              o_den,
    output logic [LANES-1:0][NUM_W-1:0]   o_num,
    output logic [LANES-1:0]              o_neg
);

    logic [1:0]                  r_v;
    logic                        r_clamp5, r_clamp6;
    logic [DEN_W-1:0]            r_den5, r_den6;
    logic signed [MX_W-1:0]      r_mx;
    logic signed [MY_W-1:0]      r_my;
    logic [LANES-1:0][NUM_W-1:0] r_num;
    logic [LANES-1:0]            r_neg;

    logic signed [DEPTH_W-1:0] depth_raw;
    logic                      clamp;
    logic [MX_W-1:0]           magx;
    logic [MY_W-1:0]           magy;

    always_comb begin
        depth_raw = $signed(DEPTH_W'(i_cfg.camera_distance)) + (DEPTH_W'(i_z2) <<< DEPTH_FRAC);
        clamp     = depth_raw < $signed(DEPTH_W'(ONE_Q8));
        magx      = r_mx[MX_W-1] ? MX_W'(-r_mx) : MX_W'(r_mx);
        magy      = r_my[MY_W-1] ? MY_W'(-r_my) : MY_W'(r_my);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_clamp5 <= clamp;
            r_den5   <= clamp ? DEN_W'(ONE_Q8) : DEN_W'(depth_raw);
            r_mx     <= i_x1 * $signed({1'b0, i_cfg.proj_gain});
            r_my     <= i_y2 * $signed({1'b0, i_cfg.proj_gain});
            // sixteenths of a pixel: scale numerator by 16
            r_num[LANE_X] <= NUM_W'(magx) << SUB_SHIFT;
            r_num[LANE_Y] <= NUM_W'(magy) << SUB_SHIFT;
            r_neg[LANE_X] <= r_mx[MX_W-1];
            r_neg[LANE_Y] <= r_my[MY_W-1];
            r_den6   <= r_den5;
            r_clamp6 <= r_clamp5;
        end
    end

    assign o_valid = r_v[1];
    assign o_clamp = r_clamp6;
    assign o_den   = r_den6;
    assign o_num   = r_num;
    assign o_neg   = r_neg;

endmodule

// File: sv/rpp_div.sv
// Two-lane restoring divider: an operand setup stage, then one quotient bit per stage.
module rpp_div import rpp_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic                        i_clamp,
    input  logic [DEN_W-1:0]            i_den,
    input  logic [LANES-1:0][NUM_W-1:0] i_num,
    input  logic [LANES-1:0]            i_neg,
    output logic                        o_valid,
    output logic                        o_clamp,
    output logic [LANES-1:0][QB-1:0]    o_quot,
    output logic [LANES-1:0]            o_ovf,
    output logic [LANES-1:0]            o_neg
);

    logic [DIV_STAGES-1:0]       r_v, n_v, r_c, n_c;
    logic [DEN_W-1:0]            r_d   [DIV_STAGES];
    logic [DEN_W-1:0]            n_d   [DIV_STAGES];
    logic [LANES-1:0][REM_W-1:0] r_rem [DIV_STAGES];
    logic [LANES-1:0][REM_W-1:0] n_rem [DIV_STAGES];
    logic [LANES-1:0][QB-1:0]    r_low [DIV_STAGES];
    logic [LANES-1:0][QB-1:0]    n_low [DIV_STAGES];
    logic [LANES-1:0][QB-1:0]    r_q   [DIV_STAGES];
    logic [LANES-1:0][QB-1:0]    n_q   [DIV_STAGES];
    logic [LANES-1:0]            r_ovf [DIV_STAGES];
    logic [LANES-1:0]            n_ovf [DIV_STAGES];
    logic [LANES-1:0]            r_neg [DIV_STAGES];
    logic [LANES-1:0]            n_neg [DIV_STAGES];

    always_comb begin
        logic [REM_W-1:0] rem2;
        rem2   = '0;
        n_v[0] = i_valid;
        n_c[0] = i_clamp;
        n_d[0] = i_den;
        n_neg[0] = i_neg;
        for (int l = 0; l < LANES; l++) begin
            // quotient of 2^QB or more always saturates: flag it up front
            n_rem[0][l] = REM_W'(i_num[l][NUM_W-1:QB]);
            n_ovf[0][l] = REM_W'(i_num[l][NUM_W-1:QB]) >= REM_W'(i_den);
            n_low[0][l] = i_num[l][QB-1:0];
            n_q[0][l]   = '0;
        end
        for (int s = 1; s < DIV_STAGES; s++) begin
            n_v[s]   = r_v[s-1];
            n_c[s]   = r_c[s-1];
            n_d[s]   = r_d[s-1];
            n_neg[s] = r_neg[s-1];
            n_ovf[s] = r_ovf[s-1];
            for (int l = 0; l < LANES; l++) begin
                rem2 = {r_rem[s-1][l][REM_W-2:0], r_low[s-1][l][QB-1]};
                if (rem2 >= REM_W'(r_d[s-1])) begin
                    n_rem[s][l] = rem2 - REM_W'(r_d[s-1]);
                    n_q[s][l]   = {r_q[s-1][l][QB-2:0], 1'b1};
                end else begin
                    n_rem[s][l] = rem2;
                    n_q[s][l]   = {r_q[s-1][l][QB-2:0], 1'b0};
                end
                n_low[s][l] = r_low[s-1][l] << 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c   <= n_c;
            r_d   <= n_d;
            r_rem <= n_rem;
            r_low <= n_low;
            r_q   <= n_q;
            r_ovf <= n_ovf;
            r_neg <= n_neg;
        end
    end

    assign o_valid = r_v[DIV_STAGES-1];
    assign o_clamp = r_c[DIV_STAGES-1];
    assign o_quot  = r_q[DIV_STAGES-1];
    assign o_ovf   = r_ovf[DIV_STAGES-1];
    assign o_neg   = r_neg[DIV_STAGES-1];

endmodule

// File: sv/rotate_project_point.sv
// Top level: rotates and perspective-projects one 3D point per cycle when not stalled.
//
// Input channel: i_valid / o_stall carry one point (i_pos_x, i_pos_y, i_pos_z);
// a point is taken at a clock edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall carry one result (o_screen_x, o_screen_y,
// o_depth_clamped, o_saturated) per point, in order.
// The path runs through 4 rotation stages, 2 projection stages, 29 divider
// stages (operand setup, then one quotient bit each) and the output register.
// One point per cycle while unstalled; the bit-per-stage divider sets depth.
// When the receiver stalls a waiting result, the whole pipeline holds and
// o_stall rises; nothing is dropped or repeated, and the pipeline moves on
// as soon as i_stall falls.
// The user writes configuration registers through i_cfg_we / i_cfg_index /
// i_cfg_data only while no point is in flight; the block does not enforce it.
// Synchronous reset empties the pipeline and loads the default angles,
// camera distance, gain and screen size.
module rotate_project_point import rpp_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_WIDTH-1:0] i_pos_x,
    input  logic signed [COORD_WIDTH-1:0] i_pos_y,
    input  logic signed [COORD_WIDTH-1:0] i_pos_z,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [OUT_W-1:0]       o_screen_x,
    output logic signed [OUT_W-1:0]       o_screen_y,
    output logic                          o_depth_clamped,
    output logic                          o_saturated
);

    t_cfg cfg;
    logic en;

    logic                        rot_valid;
    logic signed [R1_W-1:0]      rot_x1;
    logic signed [R2_W-1:0]      rot_y2, rot_z2;

    logic                        prj_valid, prj_clamp;
    logic [DEN_W-1:0]            prj_den;
    logic [LANES-1:0][NUM_W-1:0] prj_num;
    logic [LANES-1:0]            prj_neg;

    logic                        div_valid, div_clamp;
    logic [LANES-1:0][QB-1:0]    div_quot;
    logic [LANES-1:0]            div_ovf, div_neg;

    logic                        r_out_valid;
    logic signed [OUT_W-1:0]     r_sx, r_sy;
    logic                        r_clamp, r_sat;

    logic signed [SUM_W-1:0]     cx, cy, qx, qy;
    logic [OUT_W:0]              sat_x, sat_y;

    // {flag, value}: clip to the output range; a divider overflow goes to
    // the rail given by hi
    function automatic logic [OUT_W:0] sat_lane(input logic signed [SUM_W-1:0] v,
                                                input logic ovf, input logic hi);
        logic [OUT_W:0] res;
        if (ovf) begin
            res = hi ? {1'b1, OUT_W'(OUT_MAX)} : {1'b1, OUT_W'(OUT_MIN)};
        end else if (v > $signed(SUM_W'(OUT_MAX))) begin
            res = {1'b1, OUT_W'(OUT_MAX)};
        end else if (v < $signed(SUM_W'(OUT_MIN))) begin
            res = {1'b1, OUT_W'(OUT_MIN)};
        end else begin
            res = {1'b0, OUT_W'(v)};
        end
        return res;
    endfunction

    assign en      = !r_out_valid || !i_stall;
    assign o_stall = !en;

    rpp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    rpp_rotate u_rotate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_cfg   (cfg),
        .i_valid (i_valid),
        .i_pos_x (i_pos_x),
        .i_pos_y (i_pos_y),
        .i_pos_z (i_pos_z),
        .o_valid (rot_valid),
        .o_x1    (rot_x1),
        .o_y2    (rot_y2),
        .o_z2    (rot_z2)
    );

    rpp_project u_project (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_cfg   (cfg),
        .i_valid (rot_valid),
        .i_x1    (rot_x1),
        .i_y2    (rot_y2),
        .i_z2    (rot_z2),
        .o_valid (prj_valid),
        .o_clamp (prj_clamp),
        .o_den   (prj_den),
        .o_num   (prj_num),
        .o_neg   (prj_neg)
    );

    rpp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (prj_valid),
        .i_clamp (prj_clamp),
        .i_den   (prj_den),
        .i_num   (prj_num),
        .i_neg   (prj_neg),
        .o_valid (div_valid),
        .o_clamp (div_clamp),
        .o_quot  (div_quot),
        .o_ovf   (div_ovf),
        .o_neg   (div_neg)
    );

    always_comb begin
        cx = $signed(SUM_W'(cfg.screen_width) << CENTRE_SHIFT);
        cy = $signed(SUM_W'(cfg.screen_height) << CENTRE_SHIFT);
        qx = div_neg[LANE_X] ? -$signed(SUM_W'(div_quot[LANE_X]))
                             : $signed(SUM_W'(div_quot[LANE_X]));
        qy = div_neg[LANE_Y] ? -$signed(SUM_W'(div_quot[LANE_Y]))
                             : $signed(SUM_W'(div_quot[LANE_Y]));
        sat_x = sat_lane(cx + qx, div_ovf[LANE_X], !div_neg[LANE_X]);
        // screen y is inverted
        sat_y = sat_lane(cy - qy, div_ovf[LANE_Y], div_neg[LANE_Y]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sx    <= sat_x[OUT_W-1:0];
            r_sy    <= sat_y[OUT_W-1:0];
            r_clamp <= div_clamp;
            r_sat   <= sat_x[OUT_W] | sat_y[OUT_W];
        end
    end

    assign o_valid         = r_out_valid;
    assign o_screen_x      = r_sx;
    assign o_screen_y      = r_sy;
    assign o_depth_clamped = r_clamp;
    assign o_saturated     = r_sat;

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with empty output register");

    a_sat_at_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturated |->
            o_screen_x == OUT_W'(OUT_MAX) || o_screen_x == OUT_W'(OUT_MIN) ||
            o_screen_y == OUT_W'(OUT_MAX) || o_screen_y == OUT_W'(OUT_MIN))
        else $error("saturated flag without a coordinate on a rail");

    a_pipe_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(div_valid) && $stable(div_quot))
        else $error("divider pipeline moved during a stall");
`endif

endmodule

// File: tb/sv/tb.sv
// Testbench for rotate_project_point: random points against a predictor, with idles and stalls.
`timescale 1ns / 1ps

module tb;
    import rpp_pkg::*;

    typedef struct {
        logic signed [OUT_W-1:0] screen_x;
        logic signed [OUT_W-1:0] screen_y;
        logic                    clamped;
        logic                    sat;
    } t_proj;

    class proj_scoreboard;
        longint cos_yaw, sin_yaw, cos_pitch, sin_pitch;
        longint cam_dist, gain, scr_w, scr_h;
        t_proj  pending[$];
        int     errors;
        int     checked;

        function new();
            reset_regs();
            errors  = 0;
            checked = 0;
        endfunction

        function void reset_regs();
            cos_yaw = 16384; sin_yaw = 0; cos_pitch = 16384; sin_pitch = 0;
            cam_dist = 128000; gain = 256; scr_w = 800; scr_h = 600;
        endfunction

        function void set_reg(t_reg_idx idx, logic [CFG_DATA_W-1:0] v);
            case (idx)
                REG_COS_YAW:         cos_yaw   = longint'($signed(v[TRIG_W-1:0]));
                REG_SIN_YAW:         sin_yaw   = longint'($signed(v[TRIG_W-1:0]));
                REG_COS_PITCH:       cos_pitch = longint'($signed(v[TRIG_W-1:0]));
                REG_SIN_PITCH:       sin_pitch = longint'($signed(v[TRIG_W-1:0]));
                REG_CAMERA_DISTANCE: cam_dist  = longint'({1'b0, v[DIST_W-1:0]});
                REG_PROJ_GAIN:       gain      = longint'({1'b0, v[GAIN_W-1:0]});
                REG_SCREEN_WIDTH:    scr_w     = longint'({1'b0, v[SCR_W-1:0]});
                REG_SCREEN_HEIGHT:   scr_h     = longint'({1'b0, v[SCR_W-1:0]});
                default: ;
            endcase
        endfunction

        // trunc(16*a/d) toward zero, quotient limited before scaling
        function longint sub_pixel_quot(longint a, longint d);
            longint q, r;
            q = a / d;
            r = a % d;
            if (q > (64'sd1 <<< 40)) q = 64'sd1 <<< 40;
            if (q < -(64'sd1 <<< 40)) q = -(64'sd1 <<< 40);
            return q * 16 + (r * 16) / d;
        endfunction

        function longint clip(longint v, ref logic flag);
            if (v > OUT_MAX) begin
                flag = 1'b1;
                return OUT_MAX;
            end
            if (v < OUT_MIN) begin
                flag = 1'b1;
                return OUT_MIN;
            end
            return v;
        endfunction

        function void note_point(longint x, longint y, longint z);
            longint x1, z1, y2, z2, depth, sx, sy;
            t_proj  e;
            x1 = (cos_yaw * x + sin_yaw * z) / 16384;
            z1 = (cos_yaw * z - sin_yaw * x) / 16384;
            y2 = (cos_pitch * y - sin_pitch * z1) / 16384;
            z2 = (sin_pitch * y + cos_pitch * z1) / 16384;
            depth = cam_dist + z2 * ONE_Q8;
            e.clamped = 1'b0;
            e.sat     = 1'b0;
            if (depth < ONE_Q8) begin
                depth     = ONE_Q8;
                e.clamped = 1'b1;
            end
            sx = clip(scr_w * 8 + sub_pixel_quot(x1 * gain, depth), e.sat);
            sy = clip(scr_h * 8 - sub_pixel_quot(y2 * gain, depth), e.sat);
            e.screen_x = sx[OUT_W-1:0];
            e.screen_y = sy[OUT_W-1:0];
            pending.push_back(e);
        endfunction

        task report(string what, longint got, longint want);
            errors++;
            $display("MISMATCH result %0d %s: got %0d expected %0d", checked, what, got, want);
        endtask

        task check_result(t_proj r);
            t_proj e;
            if (pending.size() == 0) begin
                report("unexpected result", 1, 0);
                return;
            end
            e = pending.pop_front();
            if (r.screen_x !== e.screen_x)
                report("screen_x", longint'(r.screen_x), longint'(e.screen_x));
            if (r.screen_y !== e.screen_y)
                report("screen_y", longint'(r.screen_y), longint'(e.screen_y));
            if (r.clamped !== e.clamped)
                report("depth_clamped", longint'(r.clamped), longint'(e.clamped));
            if (r.sat !== e.sat) report("saturated", longint'(r.sat), longint'(e.sat));
            checked++;
        endtask
    endclass

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]          i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]         i_cfg_data = '0;
    logic                          i_valid = 1'b0;
    logic                          o_stall;
    logic signed [COORD_WIDTH-1:0] i_pos_x = '0;
    logic signed [COORD_WIDTH-1:0] i_pos_y = '0;
    logic signed [COORD_WIDTH-1:0] i_pos_z = '0;
    logic                          o_valid;
    logic                          i_stall = 1'b0;
    logic signed [OUT_W-1:0]       o_screen_x;
    logic signed [OUT_W-1:0]       o_screen_y;
    logic                          o_depth_clamped;
    logic                          o_saturated;

    rotate_project_point u_dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    proj_scoreboard sb = new();
    int  points_sent = 0;
    int  clamp_seen = 0;
    int  sat_seen = 0;
    int  idle_cycles = 0;
    bit  quiet = 1'b0;      // no idling on either side
    bit  hold_req = 1'b0;   // ask the receiver for one long hold-off
    bit  long_hold_done = 1'b0;

    localparam int WATCHDOG_LIMIT = 20000;

    // monitor both channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                sb.note_point(longint'(i_pos_x), longint'(i_pos_y), longint'(i_pos_z));
                points_sent++;
            end
            if (o_valid && !i_stall) begin
                t_proj r;
                r.screen_x = o_screen_x;
                r.screen_y = o_screen_y;
                r.clamped  = o_depth_clamped;
                r.sat      = o_saturated;
                clamp_seen += int'(o_depth_clamped);
                sat_seen   += int'(o_saturated);
                sb.check_result(r);
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no handshake for %0d cycles", idle_cycles);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // receiver stall, one assignment per edge
    initial begin
        int left;
        left = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_req) begin
                left = 300;
                hold_req = 1'b0;
                long_hold_done = 1'b1;
            end else if (left == 0 && !quiet && $urandom_range(0, 3) == 0) begin
                left = pick_gap();
            end
            i_stall <= (left > 0);
            if (left > 0) left--;
            @(posedge i_clk);
        end
    end

    task automatic send_point(logic [COORD_WIDTH-1:0] x, y, z);
        int g;
        i_valid <= 1'b1;
        i_pos_x <= x;
        i_pos_y <= y;
        i_pos_z <= z;
        do @(posedge i_clk); while (o_stall);
        g = pick_gap();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    // drain, then let the pipeline settle before touching registers
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [CFG_DATA_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_reg(idx, v);
    endtask

    task automatic write_all(int c_y, s_y, c_p, s_p, int cam_d, gain, w, h);
        write_reg(REG_COS_YAW, CFG_DATA_W'(c_y));
        write_reg(REG_SIN_YAW, CFG_DATA_W'(s_y));
        write_reg(REG_COS_PITCH, CFG_DATA_W'(c_p));
        write_reg(REG_SIN_PITCH, CFG_DATA_W'(s_p));
        write_reg(REG_CAMERA_DISTANCE, CFG_DATA_W'(cam_d));
        write_reg(REG_PROJ_GAIN, CFG_DATA_W'(gain));
        write_reg(REG_SCREEN_WIDTH, CFG_DATA_W'(w));
        write_reg(REG_SCREEN_HEIGHT, CFG_DATA_W'(h));
        @(posedge i_clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] rand_trig();
        // mostly unit-circle range, sometimes any pattern; upper bits are junk
        logic [CFG_DATA_W-1:0] v;
        v = CFG_DATA_W'($urandom());
        if ($urandom_range(0, 4) != 0)
            v[TRIG_W-1:0] = TRIG_W'($urandom_range(0, 32768) - 16384);
        return v;
    endfunction

    function automatic logic [COORD_WIDTH-1:0] rand_coord();
        case ($urandom_range(0, 3))
            0:       return COORD_WIDTH'($urandom());
            1:       return COORD_WIDTH'($urandom_range(0, 200000) - 100000);
            default: return COORD_WIDTH'($urandom_range(0, 4000) - 2000);
        endcase
    endfunction

    task automatic random_config();
        int cam_d, gain;
        case ($urandom_range(0, 3))
            0:       cam_d = $urandom_range(0, 2000);
            1:       cam_d = $urandom() & 24'hFFFFFF;
            default: cam_d = $urandom_range(50000, 600000);
        endcase
        gain = ($urandom_range(0, 2) == 0) ? ($urandom() & 24'hFFFFFF) :
                                             $urandom_range(0, 200000);
        write_all(rand_trig(), rand_trig(), rand_trig(), rand_trig(), cam_d, gain,
                  $urandom_range(0, 16383), $urandom_range(0, 16383));
    endtask

    localparam logic [COORD_WIDTH-1:0] C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic [COORD_WIDTH-1:0] C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values, extremes of every coordinate
        send_point(0, 0, 0);
        send_point(C_MAX, C_MAX, C_MAX);
        send_point(C_MIN, C_MIN, C_MIN);
        send_point(C_MAX, C_MIN, 24'd100);
        send_point(-24'sd1, 24'd1, -24'sd500);   // depth pulled below 1.0
        send_point(24'd300, -24'sd200, 24'd0);
        settle();

        // depth exactly 1.0 and just below, plus zero screen and max gain
        write_all(16384, 0, 16384, 0, ONE_Q8, 24'hFFFFFF, 0, 0);
        send_point(24'd5, 24'd7, 24'd0);
        send_point(24'd5, 24'd7, -24'sd1);
        send_point(-24'sd1, 24'd1, 24'd0);
        settle();

        // negative full-scale cosines, positive full-scale sines, max distance, max screen
        write_all(-16384, 16384, -16384, 16384, 24'hFFFFFF, 0, 16383, 16383);
        send_point(C_MAX, C_MIN, C_MAX);
        send_point(24'd1000, 24'd1000, 24'd1000);
        settle();

        // out-of-range trig words, zero distance
        write_all(24'h00_8000, 24'hFF_7FFF, 24'h12_8000, 24'h00_7FFF, 0, 24'd4096, 8192, 1);
        send_point(C_MIN, C_MAX, C_MIN);
        send_point(24'd3, -24'sd3, 24'd9);
        send_point(24'd0, 24'd0, C_MAX);
        settle();

        for (int ph = 0; ph < 9; ph++) begin
            random_config();
            quiet = (ph % 3 == 1);
            if (ph == 4) hold_req = 1'b1;   // sender keeps offering while receiver holds
            for (int n = 0; n < 150; n++)
                send_point(rand_coord(), rand_coord(), rand_coord());
            settle();
        end
        quiet = 1'b0;

        $display("Sent %0d points over 13 register settings; %0d results checked.",
                 points_sent, sb.checked);
        $display("Depth clamps seen: %0d, saturated results: %0d, long hold-off: %0d.",
                 clamp_seen, sat_seen, long_hold_done);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

// File: sim.f
sv/rpp_pkg.sv
sv/rpp_cfg.sv
sv/rpp_rotate.sv
sv/rpp_project.sv
sv/rpp_div.sv
sv/rotate_project_point.sv
tb/sv/tb.sv
